### design/krt_pkg.sv
// Package for the keyed record table: record layout, command and status codes,
// and the default table depth. It has no dependencies.
package krt_pkg;

  localparam int DEF_CAPACITY = 16;

  localparam int KEY_W = 31;
  localparam int QTY_W = 32;

  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_SEARCH = 3'd1;
  localparam logic [2:0] CMD_UPDATE = 3'd2;
  localparam logic [2:0] CMD_DELETE = 3'd3;
  localparam logic [2:0] CMD_LIST   = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_ZERO_KEY  = 3'd4;

  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic signed [QTY_W-1:0] qty;
  } rec_t;

  // Result of the shared compare and add unit.
  typedef struct packed {
    logic                    hit;
    logic signed [QTY_W-1:0] sum;
  } alu_res_t;

endpackage

### design/keyed_record_table.sv
// Keyed record table: a packed table of up to CAPACITY records, each a nonzero
// 31-bit key and a signed 32-bit quantity, kept in insertion order. A request
// is taken when start is high and busy is low. Insert, unknown commands and
// every request that fails at once (zero key, full table, empty table) finish
// in the accepting cycle and keep busy low; unknown commands give no result
// and the others strobe it in the next cycle. Search and update scan the table
// through the record memory's single read port, S_READ then S_CMP per entry.
// Delete scans the same way, then moves each later record down one place,
// S_SHR then S_SHW per record moved. List reads out every record, S_READ then
// S_LST per record. The receiver cannot stall: every result is on the out_
// ports for exactly one cycle, marked by out_valid, and out_last flags the
// final result of a request. Duplicate keys are allowed; lookups find the
// earliest record. Depends on krt_pkg, krt_mem and krt_alu.
module keyed_record_table #(
  parameter int CAPACITY = krt_pkg::DEF_CAPACITY
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [2:0]                           in_cmd,
  input  logic [krt_pkg::KEY_W-1:0]            in_key,
  input  logic signed [krt_pkg::QTY_W-1:0]     in_amount,
  output logic                                 out_valid,
  output logic [2:0]                           out_status,
  output logic [krt_pkg::KEY_W-1:0]            out_found_key,
  output logic signed [krt_pkg::QTY_W-1:0]     out_found_quantity,
  output logic                                 out_last
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a request
  localparam logic [2:0] S_READ = 3'd1;  // memory read of entry idx in flight
  localparam logic [2:0] S_CMP  = 3'd2;  // compare entry idx with the key
  localparam logic [2:0] S_SHR  = 3'd3;  // read entry idx+1 for the shift
  localparam logic [2:0] S_SHW  = 3'd4;  // write it back at entry idx
  localparam logic [2:0] S_LST  = 3'd5;  // report entry idx of a listing

  logic [2:0]                        state_r, state_nxt;
  logic [CW-1:0]                     count_r, count_nxt;
  logic [IW-1:0]                     idx_r, idx_nxt;
  logic [2:0]                        cmd_r, cmd_nxt;
  logic [krt_pkg::KEY_W-1:0]         key_r, key_nxt;
  logic signed [krt_pkg::QTY_W-1:0]  amount_r, amount_nxt;
  krt_pkg::rec_t                     gone_r, gone_nxt;

  logic                              out_valid_r, out_valid_nxt;
  logic [2:0]                        out_status_r, out_status_nxt;
  krt_pkg::rec_t                     out_rec_r, out_rec_nxt;
  logic                              out_last_r, out_last_nxt;

  logic                              mem_we;
  logic [IW-1:0]                     mem_waddr;
  krt_pkg::rec_t                     mem_wdata;
  logic [IW-1:0]                     mem_raddr;
  krt_pkg::rec_t                     mem_rdata;
  krt_pkg::alu_res_t                 alu_res;

  logic                              accept;
  logic [CW-1:0]                     idx_ext;
  logic                              at_end;     // idx is the last record
  logic                              shift_end;  // idx+1 is the last record

  assign accept    = start && !busy;
  assign idx_ext   = CW'(idx_r);
  assign at_end    = (idx_ext + CW'(1)) == count_r;
  assign shift_end = (idx_ext + CW'(2)) == count_r;

  krt_mem #(
    .DEPTH (CAPACITY),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  krt_alu u_alu (
    .rec    (mem_rdata),
    .key    (key_r),
    .amount (amount_r),
    .res    (alu_res)
  );

  // The read port follows idx, except while shifting, when the record above
  // idx is fetched so that it can be moved down.
  assign mem_raddr = (state_r == S_SHR) ? IW'(idx_ext + CW'(1)) : idx_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    amount_nxt     = amount_r;
    gone_nxt       = gone_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_rec_nxt    = out_rec_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r;
    mem_wdata      = mem_rdata;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt    = in_cmd;
          key_nxt    = in_key;
          amount_nxt = in_amount;
          idx_nxt    = '0;
          out_rec_nxt  = '0;
          out_last_nxt = 1'b1;
          if (in_cmd == krt_pkg::CMD_LIST) begin
            if (count_r == '0) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = krt_pkg::ST_EMPTY;
            end else begin
              state_nxt = S_READ;
            end
          end else if (in_cmd == krt_pkg::CMD_INSERT || in_cmd == krt_pkg::CMD_SEARCH ||
                       in_cmd == krt_pkg::CMD_UPDATE || in_cmd == krt_pkg::CMD_DELETE) begin
            if (in_key == '0) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = krt_pkg::ST_ZERO_KEY;
            end else if (in_cmd == krt_pkg::CMD_INSERT) begin
              out_valid_nxt = 1'b1;
              if (count_r == CW'(CAPACITY)) begin
                out_status_nxt = krt_pkg::ST_FULL;
              end else begin
                mem_we         = 1'b1;
                mem_waddr      = count_r[IW-1:0];
                mem_wdata.key  = in_key;
                mem_wdata.qty  = in_amount;
                count_nxt      = count_r + CW'(1);
                out_status_nxt = krt_pkg::ST_OK;
                out_rec_nxt    = mem_wdata;
              end
            end else if (count_r == '0) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = (in_cmd == krt_pkg::CMD_DELETE) ? krt_pkg::ST_EMPTY
                                                             : krt_pkg::ST_NOT_FOUND;
            end else begin
              state_nxt = S_READ;
            end
          end
        end
      end
      S_READ: begin
        state_nxt = (cmd_r == krt_pkg::CMD_LIST) ? S_LST : S_CMP;
      end
      S_CMP: begin
        out_last_nxt = 1'b1;
        if (alu_res.hit) begin
          out_status_nxt = krt_pkg::ST_OK;
          if (cmd_r == krt_pkg::CMD_UPDATE) begin
            mem_we         = 1'b1;
            mem_wdata.key  = mem_rdata.key;
            mem_wdata.qty  = alu_res.sum;
            out_rec_nxt    = mem_wdata;
            out_valid_nxt  = 1'b1;
            state_nxt      = S_IDLE;
          end else if (cmd_r == krt_pkg::CMD_DELETE) begin
            gone_nxt = mem_rdata;
            if (at_end) begin
              count_nxt     = count_r - CW'(1);
              out_rec_nxt   = mem_rdata;
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end else begin
              state_nxt = S_SHR;
            end
          end else begin
            out_rec_nxt   = mem_rdata;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else if (at_end) begin
          out_status_nxt = krt_pkg::ST_NOT_FOUND;
          out_rec_nxt    = '0;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          idx_nxt   = IW'(idx_ext + CW'(1));
          state_nxt = S_READ;
        end
      end
      S_SHR: begin
        state_nxt = S_SHW;
      end
      S_SHW: begin
        mem_we = 1'b1;
        if (shift_end) begin
          count_nxt      = count_r - CW'(1);
          out_status_nxt = krt_pkg::ST_OK;
          out_rec_nxt    = gone_r;
          out_last_nxt   = 1'b1;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          idx_nxt   = IW'(idx_ext + CW'(1));
          state_nxt = S_SHR;
        end
      end
      S_LST: begin
        out_status_nxt = krt_pkg::ST_OK;
        out_rec_nxt    = mem_rdata;
        out_last_nxt   = at_end;
        out_valid_nxt  = 1'b1;
        if (at_end) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = IW'(idx_ext + CW'(1));
          state_nxt = S_READ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request fields, scan position and result payload.
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    amount_r     <= amount_nxt;
    gone_r       <= gone_nxt;
    out_status_r <= out_status_nxt;
    out_rec_r    <= out_rec_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_key      = out_rec_r.key;
  assign out_found_quantity = out_rec_r.qty;
  assign out_last           = out_last_r;

  // The record count never passes the table capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("record count beyond capacity");

  // An insert with a nonzero key into a table with room succeeds next cycle.
  a_insert_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd == krt_pkg::CMD_INSERT && in_key != '0 &&
     count_r != CW'(CAPACITY))
    |=> (out_valid && out_status == krt_pkg::ST_OK && out_last &&
         count_r == $past(count_r) + CW'(1)))
    else $error("insert did not complete");

  // Every error result is final and names no record.
  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != krt_pkg::ST_OK)
    |-> (out_last && out_found_key == '0 && out_found_quantity == '0))
    else $error("malformed error result");

  // The memory is only written at entries that hold or receive a record.
  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (CW'(mem_waddr) <= count_r))
    else $error("write beyond the packed records");

endmodule

### design/krt_mem.sv
// Record memory of the keyed record table: one write port, one read port,
// registered read data. Depends on krt_pkg for the record type.
module krt_mem #(
  parameter int DEPTH = krt_pkg::DEF_CAPACITY,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  krt_pkg::rec_t     wdata,
  input  logic [AW-1:0]     raddr,
  output krt_pkg::rec_t     rdata
);

  krt_pkg::rec_t mem [DEPTH];
  krt_pkg::rec_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/krt_alu.sv
// Shared compare and saturating add unit of the keyed record table.
// Depends on krt_pkg for the record and result types.
module krt_alu (
  input  krt_pkg::rec_t                         rec,
  input  logic [krt_pkg::KEY_W-1:0]             key,
  input  logic signed [krt_pkg::QTY_W-1:0]      amount,
  output krt_pkg::alu_res_t                     res
);

  logic signed [krt_pkg::QTY_W:0] wide;

  assign wide = {rec.qty[krt_pkg::QTY_W-1], rec.qty} + {amount[krt_pkg::QTY_W-1], amount};

  always_comb begin
    res.hit = (rec.key == key);
    if (wide[krt_pkg::QTY_W] != wide[krt_pkg::QTY_W-1]) begin
      // Overflow: clamp toward the sign of the true sum.
      res.sum = wide[krt_pkg::QTY_W] ? {1'b1, {(krt_pkg::QTY_W-1){1'b0}}}
                                     : {1'b0, {(krt_pkg::QTY_W-1){1'b1}}};
    end else begin
      res.sum = wide[krt_pkg::QTY_W-1:0];
    end
  end

endmodule
